// ===== hdl/wf36_pkg.sv =====
// Package for the 36-bit word to tape frame writer.
// Holds the shared constants, request codes and item structs; depends on nothing.
`default_nettype none

package wf36_pkg;

    localparam int MAX_RECORD_WORDS = 1024;
    localparam int MIN_RECORD_WORDS = 3;
    localparam int FRAMES_PER_WORD  = 5;

    localparam int HALF_W  = 18;
    localparam int FRAME_W = 8;
    localparam int COUNT_W = 11;
    localparam int IDX_W   = 3;
    localparam int WORDS_W = 2;
    localparam int IN_TDATA_W = 40;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [HALF_W-1:0] left_half;
        logic [HALF_W-1:0] right_half;
    } req_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               frame_valid;
        logic               end_of_record;
        logic               last;
    } res_item_t;

endpackage

`default_nettype wire

// ===== hdl/wf36_in_stage.sv =====
// Input register stage of the tape frame writer.
// Holds one accepted request item until the sequencer takes it; uses wf36_pkg.
`default_nettype none

module wf36_in_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire wf36_pkg::req_item_t in_item,
    input  wire logic                take,
    output logic                     held_valid,
    output wf36_pkg::req_item_t      held_item
);

    logic                valid_reg;
    logic                valid_next;
    wf36_pkg::req_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wf36_frame_seq.sv =====
// Frame sequencer of the tape frame writer: record counter, limit register and
// the per-item frame plan, one result per cycle unless stalled; uses wf36_pkg.
`default_nettype none

module wf36_frame_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [wf36_pkg::COUNT_W-1:0] cfg_wdata,
    input  wire logic                       item_valid,
    input  wire wf36_pkg::req_item_t        item,
    output logic                            take,
    input  wire logic                       out_ready,
    output logic                            emit,
    output wf36_pkg::res_item_t             res
);

    localparam logic [wf36_pkg::COUNT_W-1:0] MaxWords =
        wf36_pkg::COUNT_W'(wf36_pkg::MAX_RECORD_WORDS);
    localparam logic [wf36_pkg::COUNT_W-1:0] MinWords =
        wf36_pkg::COUNT_W'(wf36_pkg::MIN_RECORD_WORDS);
    localparam logic [wf36_pkg::IDX_W-1:0] LastIdx =
        wf36_pkg::IDX_W'(wf36_pkg::FRAMES_PER_WORD - 1);

    logic [wf36_pkg::COUNT_W-1:0] max_reg;
    logic [wf36_pkg::COUNT_W-1:0] count_reg;
    logic [wf36_pkg::COUNT_W-1:0] count_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         marker_reg;
    logic                         marker_next;
    logic                         close_reg;
    logic                         close_next;
    logic [wf36_pkg::IDX_W-1:0]   idx_reg;
    logic [wf36_pkg::IDX_W-1:0]   idx_next;
    logic [wf36_pkg::WORDS_W-1:0] words_reg;
    logic [wf36_pkg::WORDS_W-1:0] words_next;
    logic [wf36_pkg::HALF_W-1:0]  left_reg;
    logic [wf36_pkg::HALF_W-1:0]  left_next;
    logic [wf36_pkg::HALF_W-1:0]  right_reg;
    logic [wf36_pkg::HALF_W-1:0]  right_next;

    logic [wf36_pkg::COUNT_W-1:0] eff_max;
    logic [wf36_pkg::COUNT_W:0]   count_inc;
    logic                         closes;
    logic                         final_emit;
    logic [2*wf36_pkg::HALF_W-1:0] word;
    logic [wf36_pkg::FRAME_W-1:0] frame_sel;

    always_comb
    begin
        if (max_reg < MinWords)
        begin
            eff_max = MinWords;
        end
        else if (max_reg > MaxWords)
        begin
            eff_max = MaxWords;
        end
        else
        begin
            eff_max = max_reg;
        end
        count_inc = {1'b0, count_reg} + 1'b1;
        closes    = count_inc >= {1'b0, eff_max};
    end

    always_comb
    begin
        word = {left_reg, right_reg};
        case (idx_reg)
            3'd0:    frame_sel = word[35:28];
            3'd1:    frame_sel = word[27:20];
            3'd2:    frame_sel = word[19:12];
            3'd3:    frame_sel = word[11:4];
            default: frame_sel = {4'b0000, word[3:0]};
        endcase
    end

    always_comb
    begin
        final_emit = busy_reg && (marker_reg || (idx_reg == LastIdx && words_reg == 2'd1));
        emit       = busy_reg && out_ready;
        take       = item_valid && (!busy_reg || (emit && final_emit));

        res.frame         = marker_reg ? '0 : frame_sel;
        res.frame_valid   = !marker_reg;
        res.last          = final_emit;
        res.end_of_record = final_emit && close_reg;

        busy_next   = busy_reg;
        marker_next = marker_reg;
        close_next  = close_reg;
        idx_next    = idx_reg;
        words_next  = words_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        count_next  = count_reg;

        if (emit)
        begin
            if (final_emit)
            begin
                busy_next = 1'b0;
            end
            else if (idx_reg == LastIdx)
            begin
                idx_next   = '0;
                words_next = words_reg - 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (take)
        begin
            idx_next    = '0;
            words_next  = 2'd1;
            marker_next = 1'b0;
            if (item.req_type == wf36_pkg::REQ_WRITE)
            begin
                busy_next  = 1'b1;
                close_next = closes;
                left_next  = item.left_half;
                right_next = item.right_half;
                count_next = closes ? '0 : count_inc[wf36_pkg::COUNT_W-1:0];
            end
            else
            begin
                close_next = 1'b1;
                left_next  = '0;
                right_next = '0;
                count_next = '0;
                if (count_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else if (count_reg < MinWords)
                begin
                    busy_next  = 1'b1;
                    words_next = wf36_pkg::WORDS_W'(MinWords - count_reg);
                end
                else
                begin
                    busy_next   = 1'b1;
                    marker_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= MaxWords;
            count_reg  <= '0;
            busy_reg   <= 1'b0;
            marker_reg <= 1'b0;
            close_reg  <= 1'b0;
            idx_reg    <= '0;
            words_reg  <= 2'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            count_reg  <= count_next;
            busy_reg   <= busy_next;
            marker_reg <= marker_next;
            close_reg  <= close_next;
            idx_reg    <= idx_next;
            words_reg  <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

endmodule

`default_nettype wire

// ===== hdl/wf36_out_reg.sv =====
// Output register of the tape frame writer.
// Holds one result item until the receiver takes it; uses wf36_pkg.
`default_nettype none

module wf36_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                emit,
    input  wire wf36_pkg::res_item_t res,
    output logic                     out_ready,
    output logic                     out_valid,
    input  wire logic                out_taken,
    output wf36_pkg::res_item_t      out_item
);

    logic                valid_reg;
    wf36_pkg::res_item_t item_reg;

    assign out_ready = !valid_reg || out_taken;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && emit)
        begin
            item_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/word36_to_tape_frame_writer.sv =====
// Top level of the 36-bit word to tape frame writer.
// Instantiates wf36_in_stage, wf36_frame_seq and wf36_out_reg; uses wf36_pkg.
//
// Usage: each item on the slave stream is a write of one 36-bit word
// (tuser 0) or a flush of the open record (tuser 1). A write yields five
// frame items on the master stream, the top 32 bits first and then the low
// nibble. A flush pads a record of one or two words with zero words up to
// three words, sends a bare end-of-record marker for a longer record, and
// sends nothing for an empty one. tlast marks the final result of each
// request item; tuser bit 1 marks the item that closes a tape record.
// Each request passes the input register, then the sequencer. The sequencer
// sends one frame per cycle while the output register is ready; the input
// register takes the next request while the current one is still being
// sent, so words follow each other with no gap. The record limit is to be
// written through cfg_we and cfg_wdata only while idle; the block does not
// enforce this. Reset clears the word count, empties both registers and
// sets the limit to 1024. When tready is low, the output register keeps its
// item and the sequencer and then the input side stall behind it.
`default_nettype none

module word36_to_tape_frame_writer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: left_half [17:0], right_half [35:18], zero [39:36].
    input  wire logic [39:0] s_axis_tdata,
    // tuser: req_type [0].
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: frame [7:0].
    output logic [7:0]       m_axis_tdata,
    // tuser: frame_valid [0], end_of_record [1].
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    wf36_pkg::req_item_t in_item;
    wf36_pkg::req_item_t held_item;
    wf36_pkg::res_item_t res;
    wf36_pkg::res_item_t out_item;
    logic                held_valid;
    logic                take;
    logic                emit;
    logic                out_ready;

    always_comb
    begin
        in_item.req_type   = s_axis_tuser;
        in_item.left_half  = s_axis_tdata[17:0];
        in_item.right_half = s_axis_tdata[35:18];
    end

    wf36_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    wf36_frame_seq u_frame_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (held_valid),
        .item       (held_item),
        .take       (take),
        .out_ready  (out_ready),
        .emit       (emit),
        .res        (res)
    );

    wf36_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (m_axis_tvalid),
        .out_taken (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = out_item.frame;
    assign m_axis_tuser = {out_item.end_of_record, out_item.frame_valid};
    assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire
